### sv/ptpd_pkg.sv
package ptpd_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int REG_WIDTH       = 64;
  localparam int REG_HALF        = 32;
  localparam int NUM_REGS        = 8;
  localparam int CFG_IDX_W       = 3;
  localparam int NUM_ROWS        = 4;
  localparam int NUM_COORDS      = 3;

  typedef logic [REG_WIDTH-1:0] cfg_reg_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // register index codes, column-major, two rows per register
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COL0_ROWS01 = 3'd0,
    CFG_COL0_ROWS23 = 3'd1,
    CFG_COL1_ROWS01 = 3'd2,
    CFG_COL1_ROWS23 = 3'd3,
    CFG_COL2_ROWS01 = 3'd4,
    CFG_COL2_ROWS23 = 3'd5,
    CFG_COL3_ROWS01 = 3'd6,
    CFG_COL3_ROWS23 = 3'd7
  } cfg_idx_e;

  // per-lane status handed to the merge stage
  typedef struct packed {
    logic w_zero;
    logic sat;
  } ptpd_flags_t;

endpackage

### sv/ptpd_row_lane.sv
module ptpd_row_lane #(
  parameter int CW = 32,
  parameter int FB = 16,
  parameter int RW = 2 * CW - FB + 3
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [CW-1:0] px_i,
  input  logic signed [CW-1:0] py_i,
  input  logic signed [CW-1:0] pz_i,
  input  logic signed [CW-1:0] c0_i,
  input  logic signed [CW-1:0] c1_i,
  input  logic signed [CW-1:0] c2_i,
  input  logic signed [CW-1:0] c3_i,
  output logic signed [RW-1:0] row_o
);
  import ptpd_pkg::*;

  localparam int PW = 2 * CW;
  localparam int SW = PW + 2;

  logic signed [PW-1:0] p0_q, p1_q, p2_q;
  logic signed [CW-1:0] c3_q;
  logic signed [SW-1:0] sum;
  logic signed [RW-1:0] row_d, row_q;

  // stage 1: products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q <= c0_i * px_i;
      p1_q <= c1_i * py_i;
      p2_q <= c2_i * pz_i;
      c3_q <= c3_i;
    end
  end

  // stage 2: floor of the exact sum, then translation
  always_comb begin
    sum = {{2{p0_q[PW-1]}}, p0_q} + {{2{p1_q[PW-1]}}, p1_q} + {{2{p2_q[PW-1]}}, p2_q};
    row_d = {sum[SW-1], sum[SW-1:FB]} + {{(RW-CW){c3_q[CW-1]}}, c3_q};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      row_q <= row_d;
    end
  end

  assign row_o = row_q;

endmodule

### sv/ptpd_div_lane.sv
module ptpd_div_lane #(
  parameter int CW = 32,
  parameter int FB = 16,
  parameter int RW = 2 * CW - FB + 3
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [RW-1:0]   n_i,
  input  logic signed [RW-1:0]   w_i,
  output logic signed [CW-1:0]   res_o,
  output ptpd_pkg::ptpd_flags_t  flags_o
);
  import ptpd_pkg::*;

  localparam int QW = CW + FB;
  localparam int RB = RW + 1;
  localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

  // stage a: magnitudes, zero test, plain clamp for the zero-w case
  logic          neg_a_q, zero_a_q, csat_a_q;
  logic [RW-1:0] un_a_q, ud_a_q;
  logic [CW-1:0] cval_a_q;
  logic          in_range;

  assign in_range = (n_i[RW-1:CW-1] == '0) || (n_i[RW-1:CW-1] == '1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_a_q  <= n_i[RW-1] ^ w_i[RW-1];
      un_a_q   <= n_i[RW-1] ? RW'(-n_i) : RW'(n_i);
      ud_a_q   <= w_i[RW-1] ? RW'(-w_i) : RW'(w_i);
      zero_a_q <= (w_i == '0);
      csat_a_q <= !in_range;
      cval_a_q <= in_range ? n_i[CW-1:0] : (n_i[RW-1] ? MINV : MAXV);
    end
  end

  // per-step state, index 0 is the divider setup
  logic [RB-1:0] rem_q  [QW+1];
  logic [QW-1:0] num_q  [QW+1];
  logic [QW-1:0] quo_q  [QW+1];
  logic [RW-1:0] ud_q   [QW+1];
  logic          neg_q  [QW+1];
  logic          ovf_q  [QW+1];
  logic          zero_q [QW+1];
  logic          csat_q [QW+1];
  logic [CW-1:0] cval_q [QW+1];

  // stage b: integer part overflow check and remainder setup
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0]  <= {{CW{1'b0}}, un_a_q[RW-1:CW]} >= ud_a_q;
      rem_q[0]  <= {{(CW+1){1'b0}}, un_a_q[RW-1:CW]};
      num_q[0]  <= {un_a_q[CW-1:0], {FB{1'b0}}};
      quo_q[0]  <= '0;
      ud_q[0]   <= ud_a_q;
      neg_q[0]  <= neg_a_q;
      zero_q[0] <= zero_a_q;
      csat_q[0] <= csat_a_q;
      cval_q[0] <= cval_a_q;
    end
  end

  // one restoring step per stage
  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [RB-1:0] trial;
    logic          take;
    assign trial = {rem_q[k-1][RB-2:0], num_q[k-1][QW-1]};
    assign take  = trial >= {1'b0, ud_q[k-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? (trial - {1'b0, ud_q[k-1]}) : trial;
        num_q[k]  <= {num_q[k-1][QW-2:0], 1'b0};
        quo_q[k]  <= {quo_q[k-1][QW-2:0], take};
        ud_q[k]   <= ud_q[k-1];
        neg_q[k]  <= neg_q[k-1];
        ovf_q[k]  <= ovf_q[k-1];
        zero_q[k] <= zero_q[k-1];
        csat_q[k] <= csat_q[k-1];
        cval_q[k] <= cval_q[k-1];
      end
    end
  end

  // final stage: sign and saturation
  logic [QW-1:0] q;
  logic          pos_big, neg_big;
  logic [CW-1:0] res_d;
  logic          sat_d;
  logic [CW-1:0] res_q;
  ptpd_flags_t   flags_q;

  always_comb begin
    q       = quo_q[QW];
    pos_big = |q[QW-1:CW-1];
    neg_big = (|q[QW-1:CW]) || (q[CW-1] && (|q[CW-2:0]));
    if (zero_q[QW]) begin
      res_d = cval_q[QW];
      sat_d = csat_q[QW];
    end else if (ovf_q[QW]) begin
      res_d = neg_q[QW] ? MINV : MAXV;
      sat_d = 1'b1;
    end else if (neg_q[QW]) begin
      res_d = neg_big ? MINV : CW'(-q[CW-1:0]);
      sat_d = neg_big;
    end else begin
      res_d = pos_big ? MAXV : q[CW-1:0];
      sat_d = pos_big;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q          <= res_d;
      flags_q.sat    <= sat_d;
      flags_q.w_zero <= zero_q[QW];
    end
  end

  assign res_o   = res_q;
  assign flags_o = flags_q;

endmodule

### sv/point_transform_perspective_divide.sv
// channel | direction | handshake                 | payload
// --------+-----------+---------------------------+-------------------------------------
// input   | in        | in_valid_i / in_ready_o   | point_x_i, point_y_i, point_z_i
// output  | out       | out_valid_o / out_ready_i | result_x/y/z_o, w_was_zero_o, saturated_o
// config  | in        | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// one point per cycle while the pipe is not held; the path to the output register runs through the row lanes
// and the divider, which retires one quotient bit per stage
// reset loads the identity matrix and empties the pipe
// the whole pipe advances together; it holds only while the output register is full
// and not taken, so in_ready_o is low exactly then
module point_transform_perspective_divide #(
  parameter int COORD_WIDTH = ptpd_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = ptpd_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_WIDTH-1:0] result_x_o,
  output logic signed [COORD_WIDTH-1:0] result_y_o,
  output logic signed [COORD_WIDTH-1:0] result_z_o,
  output logic                          w_was_zero_o,
  output logic                          saturated_o,
  input  logic                          cfg_we_i,
  input  ptpd_pkg::cfg_idx_t            cfg_idx_i,
  input  ptpd_pkg::cfg_reg_t            cfg_data_i
);
  import ptpd_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int RW  = 2 * CW - FRAC_BITS + 3;
  localparam int LAT = CW + FRAC_BITS + 5;   // row lanes 2, divide lanes QW + 3

  // matrix registers
  cfg_reg_t regs_q [NUM_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // identity: 1.0 on the diagonal
      regs_q[CFG_COL0_ROWS01] <= REG_WIDTH'(1) << FRAC_BITS;
      regs_q[CFG_COL0_ROWS23] <= '0;
      regs_q[CFG_COL1_ROWS01] <= REG_WIDTH'(1) << (FRAC_BITS + REG_HALF);
      regs_q[CFG_COL1_ROWS23] <= '0;
      regs_q[CFG_COL2_ROWS01] <= '0;
      regs_q[CFG_COL2_ROWS23] <= REG_WIDTH'(1) << FRAC_BITS;
      regs_q[CFG_COL3_ROWS01] <= '0;
      regs_q[CFG_COL3_ROWS23] <= REG_WIDTH'(1) << (FRAC_BITS + REG_HALF);
    end else if (cfg_we_i) begin
      regs_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // pipe advance: stall only on a full, untaken output register
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  logic [LAT-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // four row lanes: x', y', z', w'
  logic signed [RW-1:0] row [NUM_ROWS];

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
    localparam int RIDX = r / 2;
    localparam int ROFS = (r % 2) * REG_HALF;
    localparam cfg_idx_t I0 = cfg_idx_t'(int'(CFG_COL0_ROWS01) + RIDX);
    localparam cfg_idx_t I1 = cfg_idx_t'(int'(CFG_COL1_ROWS01) + RIDX);
    localparam cfg_idx_t I2 = cfg_idx_t'(int'(CFG_COL2_ROWS01) + RIDX);
    localparam cfg_idx_t I3 = cfg_idx_t'(int'(CFG_COL3_ROWS01) + RIDX);
    ptpd_row_lane #(.CW(CW), .FB(FRAC_BITS), .RW(RW)) u_row (
      .clk_i (clk_i),
      .en_i  (en),
      .px_i  (point_x_i),
      .py_i  (point_y_i),
      .pz_i  (point_z_i),
      .c0_i  (regs_q[I0][ROFS +: CW]),
      .c1_i  (regs_q[I1][ROFS +: CW]),
      .c2_i  (regs_q[I2][ROFS +: CW]),
      .c3_i  (regs_q[I3][ROFS +: CW]),
      .row_o (row[r])
    );
  end

  // three divide lanes share w'
  logic signed [CW-1:0] res   [NUM_COORDS];
  ptpd_flags_t          flags [NUM_COORDS];

  for (genvar c = 0; c < NUM_COORDS; c++) begin : g_div
    ptpd_div_lane #(.CW(CW), .FB(FRAC_BITS), .RW(RW)) u_div (
      .clk_i   (clk_i),
      .en_i    (en),
      .n_i     (row[c]),
      .w_i     (row[NUM_ROWS-1]),
      .res_o   (res[c]),
      .flags_o (flags[c])
    );
  end

  // merge into the output register
  logic signed [CW-1:0] rx_q, ry_q, rz_q;
  logic                 wz_q, sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rx_q  <= res[0];
      ry_q  <= res[1];
      rz_q  <= res[2];
      wz_q  <= flags[0].w_zero;
      sat_q <= flags[0].sat | flags[1].sat | flags[2].sat;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign result_x_o   = rx_q;
  assign result_y_o   = ry_q;
  assign result_z_o   = rz_q;
  assign w_was_zero_o = wz_q;
  assign saturated_o  = sat_q;

endmodule

### dv/point_transform_perspective_divide_tb.sv
`timescale 1ns / 100ps

module point_transform_perspective_divide_tb;
  import ptpd_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  // divider pipe depth plus margin for the drain at the end
  localparam int PIPE_DEPTH = CW + FB + 6;
  localparam int IDLE_LIMIT = 4000;
  localparam int NUM_RANDOM = 1430;

  localparam logic signed [CW-1:0] MAX_C = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MIN_C = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] ONE_C = 1 <<< FB;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 w_zero;
    logic                 sat;
  } vertex_out_t;

  typedef struct {
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] pz;
    logic                 typed;   // expected result typed in below
    vertex_out_t          res;
  } vertex_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic signed [CW-1:0] point_x_i;
  logic signed [CW-1:0] point_y_i;
  logic signed [CW-1:0] point_z_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic signed [CW-1:0] result_x_o;
  logic signed [CW-1:0] result_y_o;
  logic signed [CW-1:0] result_z_o;
  logic                 w_was_zero_o;
  logic                 saturated_o;
  logic                 cfg_we_i;
  cfg_idx_t             cfg_idx_i;
  cfg_reg_t             cfg_data_i;

  point_transform_perspective_divide DUT (.*);

  // testbench copy of the matrix
  cfg_reg_t    matrix_regs [NUM_REGS];
  vertex_out_t pending_vertices [$];
  int          mismatch_count;
  int          result_count;
  int          wzero_count;
  int          sat_count;
  int          idle_cycles;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_off;
  bit          timed_out;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // coefficient of column col, row row from the packed registers
  function automatic logic signed [63:0] matrix_coef(int col, int row);
    cfg_reg_t r;
    logic signed [CW-1:0] c;
    r = matrix_regs[col*2 + row/2];
    c = (row % 2) ? r[REG_HALF +: CW] : r[CW-1:0];
    return 64'(c);
  endfunction

  // floor of the summed products plus the translation, kept exact in 128 bits
  function automatic logic signed [127:0] row_sum(int row, logic signed [CW-1:0] px,
      logic signed [CW-1:0] py, logic signed [CW-1:0] pz);
    logic signed [127:0] acc;
    acc = 128'(matrix_coef(0, row)) * 128'(px) + 128'(matrix_coef(1, row)) * 128'(py)
        + 128'(matrix_coef(2, row)) * 128'(pz);
    return (acc >>> FB) + 128'(matrix_coef(3, row));
  endfunction

  function automatic logic signed [CW-1:0] clamp_coord(logic signed [127:0] v,
      ref logic sat);
    if (v > 128'(MAX_C)) begin
      sat = 1'b1;
      return MAX_C;
    end
    if (v < 128'(MIN_C)) begin
      sat = 1'b1;
      return MIN_C;
    end
    return v[CW-1:0];
  endfunction

  // (n << FB) / d truncated toward zero, with the early overflow out of the
  // integer quotient
  function automatic logic signed [CW-1:0] fixed_divide(logic signed [127:0] n,
      logic signed [127:0] d, ref logic sat);
    logic         neg;
    logic [127:0] un;
    logic [127:0] ud;
    logic [127:0] q;
    neg = (n < 0) != (d < 0);
    un  = (n < 0) ? -n : n;
    ud  = (d < 0) ? -d : d;
    q   = un / ud;
    if (q >= (128'd1 << CW)) begin
      sat = 1'b1;
      return neg ? MIN_C : MAX_C;
    end
    q = (un << FB) / ud;
    return clamp_coord(neg ? -$signed(q) : $signed(q), sat);
  endfunction

  function automatic vertex_out_t project_vertex(logic signed [CW-1:0] px,
      logic signed [CW-1:0] py, logic signed [CW-1:0] pz);
    logic signed [127:0] v [3];
    logic signed [127:0] w;
    logic signed [CW-1:0] r [3];
    logic sat;
    vertex_out_t o;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) v[i] = row_sum(i, px, py, pz);
    w = row_sum(3, px, py, pz);
    for (int i = 0; i < 3; i++)
      r[i] = (w != 0) ? fixed_divide(v[i], w, sat) : clamp_coord(v[i], sat);
    o.x = r[0];
    o.y = r[1];
    o.z = r[2];
    o.w_zero = (w == 0);
    o.sat = sat;
    return o;
  endfunction

  function automatic cfg_reg_t pack_pair(logic signed [CW-1:0] lo, logic signed [CW-1:0] hi);
    return {hi, lo};
  endfunction

  function automatic logic signed [CW-1:0] random_coord();
    case ($urandom_range(0, 9))
      0:       return MAX_C;
      1:       return MIN_C;
      2:       return '0;
      3, 4:    return $signed($urandom());
      default: return $signed(CW'($urandom_range(0, 40 << FB))) - (20 <<< FB);
    endcase
  endfunction

  function automatic cfg_reg_t random_reg();
    if ($urandom_range(0, 3) == 0) return {$urandom(), $urandom()};
    return pack_pair(random_coord() >>> $urandom_range(0, 12),
                     random_coord() >>> $urandom_range(0, 12));
  endfunction

  // register write, only while the pipe is empty
  task automatic write_reg(cfg_idx_e idx, cfg_reg_t data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    matrix_regs[idx] = data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_vertices.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
  endtask

  // offer one point; valid stays high until the transfer
  task automatic send_point(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
      logic signed [CW-1:0] pz);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    point_x_i  <= px;
    point_y_i  <= py;
    point_z_i  <= pz;
    pending_vertices.push_back(project_vertex(px, py, pz));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic check_typed(vertex_out_t want);
    vertex_out_t got;
    got = pending_vertices[pending_vertices.size()-1];
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("typed row mismatch: table %h predictor %h", want, got);
    end
  endtask

  // receiver side: random stalls plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // result check on every output transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      vertex_out_t got;
      vertex_out_t want;
      got = '{result_x_o, result_y_o, result_z_o, w_was_zero_o, saturated_o};
      if (pending_vertices.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("result with nothing expected: %h", got);
      end else begin
        want = pending_vertices.pop_front();
        result_count++;
        wzero_count += want.w_zero;
        sat_count   += want.sat;
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: x %h/%h y %h/%h z %h/%h wz %b/%b sat %b/%b (exp/act)",
                     want.x, got.x, want.y, got.y, want.z, got.z,
                     want.w_zero, got.w_zero, want.sat, got.sat);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    vertex_row_t dir_rows [$];
    vertex_row_t row;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    point_x_i     = '0;
    point_y_i     = '0;
    point_z_i     = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_COL0_ROWS01;
    cfg_data_i    = '0;
    hold_off      = 1'b0;
    send_idle_pct = 17;
    recv_idle_pct = 45;
    mismatch_count = 0;
    result_count  = 0;
    wzero_count   = 0;
    sat_count     = 0;
    // identity after reset
    matrix_regs[CFG_COL0_ROWS01] = pack_pair(ONE_C, '0);
    matrix_regs[CFG_COL0_ROWS23] = '0;
    matrix_regs[CFG_COL1_ROWS01] = pack_pair('0, ONE_C);
    matrix_regs[CFG_COL1_ROWS23] = '0;
    matrix_regs[CFG_COL2_ROWS01] = '0;
    matrix_regs[CFG_COL2_ROWS23] = pack_pair(ONE_C, '0);
    matrix_regs[CFG_COL3_ROWS01] = '0;
    matrix_regs[CFG_COL3_ROWS23] = pack_pair('0, ONE_C);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table under the identity: point comes back unchanged
    dir_rows.push_back('{'0, '0, '0, 1'b1, '{'0, '0, '0, 1'b0, 1'b0}});
    dir_rows.push_back('{MAX_C, MAX_C, MAX_C, 1'b1, '{MAX_C, MAX_C, MAX_C, 1'b0, 1'b0}});
    dir_rows.push_back('{MIN_C, MIN_C, MIN_C, 1'b1, '{MIN_C, MIN_C, MIN_C, 1'b0, 1'b0}});
    dir_rows.push_back('{ONE_C, -ONE_C, 32'sd1, 1'b1, '{ONE_C, -ONE_C, 32'sd1, 1'b0, 1'b0}});
    dir_rows.push_back('{MAX_C, MIN_C, -32'sd1, 1'b1, '{MAX_C, MIN_C, -32'sd1, 1'b0, 1'b0}});
    foreach (dir_rows[i]) begin
      send_point(dir_rows[i].px, dir_rows[i].py, dir_rows[i].pz);
      if (dir_rows[i].typed) check_typed(dir_rows[i].res);
    end
    in_valid_i <= 1'b0;
    wait_drained();

    // w offset zero, no w row: every point has w zero, undivided values out
    write_reg(CFG_COL3_ROWS23, pack_pair(ONE_C, '0));
    row = '{32'sd5, -32'sd7, MIN_C, 1'b1, '{32'sd5, -32'sd7, MIN_C + ONE_C, 1'b1, 1'b0}};
    send_point(row.px, row.py, row.pz);
    check_typed(row.res);
    in_valid_i <= 1'b0;
    wait_drained();
    // scale x by max: clamps high and low with w zero
    write_reg(CFG_COL0_ROWS01, pack_pair(MAX_C, '0));
    row = '{MAX_C, '0, '0, 1'b1, '{MAX_C, '0, ONE_C, 1'b1, 1'b1}};
    send_point(row.px, row.py, row.pz);
    check_typed(row.res);
    row = '{MIN_C, '0, '0, 1'b1, '{MIN_C, '0, ONE_C, 1'b1, 1'b1}};
    send_point(row.px, row.py, row.pz);
    check_typed(row.res);
    in_valid_i <= 1'b0;
    wait_drained();

    // tiny w divides into overflow; w from z for a real perspective divide
    write_reg(CFG_COL0_ROWS01, pack_pair(ONE_C, '0));
    write_reg(CFG_COL3_ROWS23, pack_pair('0, 32'sd1));
    send_point(MAX_C, MIN_C, ONE_C);
    send_point('0, '0, '0);
    in_valid_i <= 1'b0;
    wait_drained();
    write_reg(CFG_COL2_ROWS23, pack_pair(ONE_C, ONE_C));
    write_reg(CFG_COL3_ROWS23, '0);
    for (int i = 0; i < 12; i++) send_point(random_coord(), random_coord(), random_coord());
    send_point(32'sd3, -32'sd9, -ONE_C);
    send_point(MIN_C, MAX_C, 32'sd1);
    in_valid_i <= 1'b0;
    wait_drained();

    // random part in three idling phases, a new matrix every block of items
    for (int k = 0; k < NUM_RANDOM; k++) begin
      if (k == NUM_RANDOM / 3) begin
        send_idle_pct = 45;
        recv_idle_pct = 17;
      end else if (k == 2 * NUM_RANDOM / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (k % 110 == 0) begin
        in_valid_i <= 1'b0;
        wait_drained();
        for (int r = 0; r < NUM_REGS; r++)
          if (k == 0 || $urandom_range(0, 2) != 0) write_reg(cfg_idx_e'(r), random_reg());
        // extreme settings now and then
        if (k % 440 == 220) write_reg(CFG_COL3_ROWS23, {$urandom(), 32'h0});
        if (k % 440 == 330) write_reg(CFG_COL0_ROWS01, {MIN_C, MAX_C});
      end
      // long receiver hold-off so the pipe fills and input stalls
      if (k == 900) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (3 * PIPE_DEPTH) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      send_point(random_coord(), random_coord(), random_coord());
    end
    in_valid_i <= 1'b0;
    wait_drained();

    $display("covered %0d results, %0d with w zero, %0d saturated, across %0d matrices",
             result_count, wzero_count, sat_count, NUM_RANDOM / 110 + 5);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    timed_out = 1'b0;
    wait (idle_cycles >= IDLE_LIMIT);
    $display("watchdog: no transfer in %0d cycles, %0d results outstanding",
             IDLE_LIMIT, pending_vertices.size());
    $display("status: fail");
    $finish;
  end

endmodule
